/* rtl/assert_macros.svh */
// assertion helpers for the gamut compression block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the following cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gctn_pkg.sv */
package gctn_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W = 32;
    localparam int PEAK_W = 30;
    localparam int SCALE_W = FRAC_BITS + 1;
    // magnitude of a delta between a 32-bit signed value and a 30-bit neutral
    localparam int MAG_W = 33;
    // dividend width: numerator (30 bits) shifted by the fraction bits
    localparam int DIVD_W = PEAK_W + FRAC_BITS;
    // quotient digits that matter: any quotient at or above one is capped
    localparam int QD = FRAC_BITS + 1;
    localparam int LAT = QD + 4;
    localparam logic [PEAK_W-1:0] PEAK_RESET = PEAK_W'(6553600);
    localparam int ADDR_W = 2;
    localparam logic [ADDR_W-1:0] REG_PEAK = '0;

    typedef struct packed {
        logic signed [IN_W-1:0] red_nits;
        logic signed [IN_W-1:0] green_nits;
        logic signed [IN_W-1:0] blue_nits;
        logic signed [IN_W-1:0] target_luma;
    } t_in;

    typedef struct packed {
        logic [PEAK_W-1:0]  red_out;
        logic [PEAK_W-1:0]  green_out;
        logic [PEAK_W-1:0]  blue_out;
        logic [SCALE_W-1:0] chroma_scale;
    } t_out;

    // per-lane channel info carried down the pipe
    typedef struct packed {
        logic              neg;
        logic [MAG_W-1:0]  mag;
    } t_lane;

endpackage

/* rtl/gctn_if.sv */
interface gctn_in_if;
    import gctn_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gctn_out_if;
    import gctn_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/gamut_compress_toward_neutral.sv */
// pipeline: input register, 17 divider stages, min, multiply and output registers
// throughput: one pixel per cycle while the output is not stalled, set by the fully pipelined per-channel dividers
// the pipeline freezes as a whole while a finished result is stalled at the output
// reset (synchronous, active low) clears valid bits and sets peak to 100 nits
module gamut_compress_toward_neutral
    import gctn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    gctn_in_if.sink           s_in,
    gctn_out_if.source        m_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic [PEAK_W-1:0] r_peak;
    logic [LAT-1:0]    r_vld;
    logic              n_en;
    t_in               r_in;
    logic [PEAK_W-1:0] r_neutral [QD+2];
    t_lane             w_lane [3];
    logic [SCALE_W-1:0] w_cand [3];
    logic signed [IN_W-1:0] w_chan [3];
    t_lane             r_lane2 [3];
    logic [SCALE_W-1:0] r_scale, r_scale2;
    logic [MAG_W+SCALE_W-1:0] r_prod [3];
    logic [PEAK_W-1:0] r_pk [QD+2];
    t_out              r_out;
    logic [PEAK_W-1:0] n_res [3];

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_PEAK) ? {2'b0, r_peak} : '0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= PEAK_RESET;
        end else if (psel && penable && pwrite && paddr == REG_PEAK) begin
            r_peak <= pwdata[PEAK_W-1:0];
        end
    end

    // whole pipe advances unless output is stalled
    assign n_en = !r_vld[LAT-1] || m_out.ready;
    assign s_in.ready = n_en;
    assign m_out.valid = r_vld[LAT-1];
    assign m_out.data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[LAT-2:0], s_in.valid};
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (n_en) r_in <= s_in.data;
    end

    // neutral clamp, combinational on registered input
    logic [PEAK_W-1:0] n_neu;
    always_comb begin
        if (r_in.target_luma[IN_W-1]) n_neu = '0;
        else if (r_in.target_luma > $signed({2'b0, r_peak})) n_neu = r_peak;
        else n_neu = r_in.target_luma[PEAK_W-1:0];
    end

    assign w_chan[0] = r_in.red_nits;
    assign w_chan[1] = r_in.green_nits;
    assign w_chan[2] = r_in.blue_nits;

    for (genvar l = 0; l < 3; l++) begin : g_lane
        gctn_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (n_en),
            .i_chan    (w_chan[l]),
            .i_neutral (n_neu),
            .i_peak    (r_peak),
            .o_lane    (w_lane[l]),
            .o_cand    (w_cand[l])
        );
    end

    // neutral and peak follow the lanes
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_neutral[0] <= n_neu;
            r_pk[0] <= r_peak;
            for (int s = 1; s < QD + 2; s++) r_neutral[s] <= r_neutral[s-1];
            for (int s = 1; s < QD + 2; s++) r_pk[s] <= r_pk[s-1];
        end
    end

    // merge: minimum of the candidates
    logic [SCALE_W-1:0] n_m01;
    assign n_m01 = (w_cand[0] < w_cand[1]) ? w_cand[0] : w_cand[1];
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_scale <= (w_cand[2] < n_m01) ? w_cand[2] : n_m01;
            for (int l = 0; l < 3; l++) r_lane2[l] <= w_lane[l];
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_scale2 <= r_scale;
            for (int l = 0; l < 3; l++) r_prod[l] <= r_lane2[l].mag * r_scale;
        end
    end
    logic r_neg3 [3];
    always_ff @(posedge i_clk) begin
        if (n_en) for (int l = 0; l < 3; l++) r_neg3[l] <= r_lane2[l].neg;
    end

    // rebuild and clamp each channel
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            logic [MAG_W:0] part;
            logic signed [MAG_W+1:0] v;
            part = (MAG_W+1)'(r_prod[l] >> FRAC_BITS);
            v = r_neg3[l] ? (MAG_W+2)'(r_neutral[QD+1]) - (MAG_W+2)'(part)
                          : (MAG_W+2)'(r_neutral[QD+1]) + (MAG_W+2)'(part);
            if (v < 0) n_res[l] = '0;
            else if (v > $signed((MAG_W+2)'(r_pk[QD+1]))) n_res[l] = r_pk[QD+1];
            else n_res[l] = v[PEAK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_out <= '{red_out: n_res[0], green_out: n_res[1], blue_out: n_res[2],
                       chroma_scale: r_scale2};
        end
    end
endmodule

/* rtl/gctn_div.sv */
// pipelined restoring divider, an integer check stage then one quotient bit per stage, quotient saturated to one
module gctn_div
    import gctn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [PEAK_W-1:0]  i_num,
    input  logic [MAG_W-1:0]   i_den,
    output logic [SCALE_W-1:0] o_q
);
    localparam int RW = MAG_W + 1;

    // the quotient is at least one when num >= den; otherwise long division
    // over the FRAC_BITS fraction digits with remainder < den
    logic [RW-1:0]      r_rem [QD];
    logic [MAG_W-1:0]   r_den [QD];
    logic [SCALE_W-1:0] r_q   [QD];
    logic               r_sat [QD];

    // stage 0: integer part check
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            if ({3'b0, i_num} >= i_den) begin
                r_sat[0] <= 1'b1;
                r_rem[0] <= '0;
            end else begin
                r_sat[0] <= 1'b0;
                r_rem[0] <= RW'(i_num);
            end
        end
    end

    // one fraction digit per stage
    for (genvar s = 1; s < QD; s++) begin : g_st
        logic [RW-1:0] n_sh;
        logic          n_ge;
        assign n_sh = {r_rem[s-1][RW-2:0], 1'b0};
        assign n_ge = n_sh >= {1'b0, r_den[s-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= r_den[s-1];
                r_sat[s] <= r_sat[s-1];
                r_rem[s] <= n_ge ? n_sh - {1'b0, r_den[s-1]} : n_sh;
                r_q[s]   <= {r_q[s-1][SCALE_W-2:0], n_ge};
            end
        end
    end

    assign o_q = r_sat[QD-1] ? SCALE_W'(1 << FRAC_BITS) : r_q[QD-1];
endmodule

/* rtl/gctn_lane.sv */
// one channel lane: delta, candidate scale through the divider
module gctn_lane
    import gctn_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [IN_W-1:0] i_chan,
    input  logic [PEAK_W-1:0]      i_neutral,
    input  logic [PEAK_W-1:0]      i_peak,
    output t_lane                  o_lane,
    output logic [SCALE_W-1:0]     o_cand
);
    logic signed [MAG_W:0] n_delta;
    logic [MAG_W-1:0]      n_mag;
    logic [PEAK_W-1:0]     n_num;
    t_lane                 r_lane [QD];

    assign n_delta = (MAG_W+1)'(i_chan) - (MAG_W+1)'({1'b0, i_neutral});
    assign n_mag = n_delta[MAG_W] ? MAG_W'(-n_delta) : n_delta[MAG_W-1:0];
    assign n_num = n_delta[MAG_W] ? i_neutral : i_peak - i_neutral;

    // no candidate for a neutral channel: force the saturated quotient of one
    gctn_div u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ((n_mag == '0) ? PEAK_W'(1) : n_num),
        .i_den ((n_mag == '0) ? MAG_W'(1) : n_mag),
        .o_q   (o_cand)
    );

    // lane info follows the divider
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane[0] <= '{neg: n_delta[MAG_W], mag: n_mag};
            for (int s = 1; s < QD; s++) r_lane[s] <= r_lane[s-1];
        end
    end
    assign o_lane = r_lane[QD-1];
endmodule

/* rtl/gctn_checker.sv */
`include "assert_macros.svh"

// port-level checks on the gamut compression block
module gctn_checker
    import gctn_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input t_out              out_data
);
    localparam logic [SCALE_W-1:0] ONE = SCALE_W'(1 << FRAC_BITS);

    `CHK_ALWAYS(a_scale_max, i_clk, i_rst_n, !out_valid || out_data.chroma_scale <= ONE, "scale")
    `CHK_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "hold")
    `CHK_ALWAYS(a_ready, i_clk, i_rst_n, out_valid || in_ready, "input blocked while empty")
    `CHK_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !out_valid, "result after reset")
endmodule

bind gamut_compress_toward_neutral gctn_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (s_in.ready),
    .out_valid (m_out.valid),
    .out_ready (m_out.ready),
    .out_data  (m_out.data)
);
